[sv/kwm_pkg.sv]
// shared types, codes and defaults for the k-way timestamp merge unit
package kwm_pkg;

    // default values of the top level parameters
    localparam int NUM_SOURCES_DEF = 8;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int TAG_WIDTH_DEF   = 32;

    // configuration port widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    // input opcodes
    localparam logic OP_HEAD = 1'b0;
    localparam logic OP_END  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_COUNT = 2'd0,
        CFG_ADD_SOURCE   = 2'd1
    } t_cfg_reg;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_RECORD = 2'd0,
        STATUS_ERROR  = 2'd1,
        STATUS_ENDED  = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // input word
    typedef struct packed {
        logic        opcode;
        logic [2:0]  source_index;
        logic [31:0] timestamp;
        logic [31:0] record_tag;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  source_out;
        logic [31:0] time_out;
        logic [31:0] tag_out;
        logic        last;
    } t_out_word;

endpackage

[sv/kwm_head_ram.sv]
// head record memory: one write port, one registered read port
module kwm_head_ram #(
    parameter int DEPTH = kwm_pkg::NUM_SOURCES_DEF,
    parameter int WIDTH = kwm_pkg::TIME_WIDTH_DEF + kwm_pkg::TAG_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/kway_timestamp_merge_unit.sv]
// k-way timestamp merge unit: top level with head flags, scan and emit sequencer
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | start, busy, i_in                         | in
//  result   | o_strobe, o_out                           | out
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index/data | in
//
// An error or all-ended result shows on the cycle after acceptance. A word
// that completes the set of heads starts a round: a scan through the single
// read port of the head memory finds the smallest nonzero time (or, with no
// nonzero head, the zero-time heads), then the tied records are emitted one
// after another, lowest source first; busy stays high through the round.
// Reset clears all heads and opens all sources. The result side cannot
// stall; every result is one strobed cycle.
module kway_timestamp_merge_unit #(
    parameter int NUM_SOURCES = kwm_pkg::NUM_SOURCES_DEF,
    parameter int TIME_WIDTH  = kwm_pkg::TIME_WIDTH_DEF,
    parameter int TAG_WIDTH   = kwm_pkg::TAG_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  kwm_pkg::t_in_word                  i_in,
    output logic                               o_strobe,
    output kwm_pkg::t_out_word                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kwm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [kwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import kwm_pkg::*;

    localparam int IW = $clog2(NUM_SOURCES);
    localparam int XW = (IW >= 4) ? IW + 1 : 5;
    localparam int MW = TIME_WIDTH + TAG_WIDTH;
    localparam logic [3:0] COUNT_RST = 4'((NUM_SOURCES < 8) ? NUM_SOURCES : 8);
    localparam logic [NUM_SOURCES-1:0] ONE = NUM_SOURCES'(1);

    // registers
    t_state                  r_state, n_state;
    logic [3:0]              r_count;
    logic                    r_add_src;
    logic [NUM_SOURCES-1:0]  r_valid, n_valid;
    logic [NUM_SOURCES-1:0]  r_open, n_open;
    logic [XW-1:0]           r_ptr, n_ptr;
    logic                    r_rd_vld, n_rd_vld;
    logic [IW-1:0]           r_rd_idx, n_rd_idx;
    logic                    r_have, n_have;
    logic [TIME_WIDTH-1:0]   r_min, n_min;
    logic [NUM_SOURCES-1:0]  r_nz_mask, n_nz_mask;
    logic [NUM_SOURCES-1:0]  r_z_mask, n_z_mask;
    logic [NUM_SOURCES-1:0]  r_emit_mask, n_emit_mask;
    logic                    r_emit_vld, n_emit_vld;
    logic                    r_emit_last, n_emit_last;
    logic                    r_msg_vld, n_msg_vld;
    t_status                 r_msg_status, n_msg_status;

    // combinational signals
    logic                    w_accept;
    logic [IW-1:0]           w_sidx;
    logic                    w_bad;
    logic                    w_ok;
    logic [NUM_SOURCES-1:0]  w_in_use;
    logic [NUM_SOURCES-1:0]  w_sbit;
    logic [NUM_SOURCES-1:0]  w_upd_valid;
    logic [NUM_SOURCES-1:0]  w_upd_open;
    logic                    w_any_open;
    logic                    w_all_full;
    logic                    w_round;
    logic                    w_scan_issue;
    logic                    w_scan_done;
    logic                    w_emit_issue;
    logic [IW-1:0]           w_pick;
    logic [NUM_SOURCES-1:0]  w_mask_rest;
    logic                    w_we;
    logic [MW-1:0]           w_wdata;
    logic                    w_re;
    logic [IW-1:0]           w_raddr;
    logic [MW-1:0]           w_rdata;
    logic [TIME_WIDTH-1:0]   w_rd_time;
    logic [TAG_WIDTH-1:0]    w_rd_tag;
    logic [NUM_SOURCES-1:0]  w_rd_bit;
    logic                    w_rd_live;

    // head record memory
    kwm_head_ram #(
        .DEPTH (NUM_SOURCES),
        .WIDTH (MW)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_sidx),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_time = w_rdata[MW-1:TAG_WIDTH];
    assign w_rd_tag  = w_rdata[TAG_WIDTH-1:0];

    // input checks and head flag update for an accepted word
    always_comb begin
        w_accept = start && !busy;
        w_sidx   = IW'(i_in.source_index);
        w_sbit   = ONE << w_sidx;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            w_in_use[i] = XW'(i) < XW'(r_count);
        end
        w_bad = (XW'(i_in.source_index) >= XW'(r_count))
              || !r_open[w_sidx] || r_valid[w_sidx];
        w_ok  = w_accept && !w_bad;
        w_upd_valid = r_valid;
        w_upd_open  = r_open;
        if (w_ok && i_in.opcode == OP_HEAD) begin
            w_upd_valid = r_valid | w_sbit;
        end
        if (w_ok && i_in.opcode == OP_END) begin
            w_upd_open = r_open & ~w_sbit;
        end
        w_any_open = |(w_upd_open & w_in_use);
        w_all_full = ~|(w_upd_open & ~w_upd_valid & w_in_use);
        w_round    = w_ok && w_any_open && w_all_full;
        w_we       = w_ok && i_in.opcode == OP_HEAD;
        w_wdata    = {TIME_WIDTH'(i_in.timestamp), TAG_WIDTH'(i_in.record_tag)};
    end

    // lowest pending source of the emission mask
    always_comb begin
        w_pick = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (r_emit_mask[i]) begin
                w_pick = IW'(i);
            end
        end
        w_mask_rest = r_emit_mask & ~(ONE << w_pick);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_round) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_mask_rest == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs: handshake and memory read control
    always_comb begin
        busy         = 1'b1;
        w_scan_issue = 1'b0;
        w_scan_done  = 1'b0;
        w_emit_issue = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_SCAN: begin
                w_scan_issue = r_ptr < XW'(r_count);
                w_scan_done  = !w_scan_issue && !r_rd_vld;
            end
            ST_EMIT: begin
                w_emit_issue = 1'b1;
            end
            default: busy = 1'b1;
        endcase
        w_re    = w_scan_issue || w_emit_issue;
        w_raddr = w_emit_issue ? w_pick : r_ptr[IW-1:0];
    end

    // scan compare, emission and result bookkeeping
    always_comb begin
        w_rd_bit  = ONE << r_rd_idx;
        w_rd_live = r_valid[r_rd_idx] && r_open[r_rd_idx];

        n_valid      = w_upd_valid;
        n_open       = w_upd_open;
        n_ptr        = r_ptr;
        n_rd_vld     = w_scan_issue;
        n_rd_idx     = w_re ? w_raddr : r_rd_idx;
        n_have       = r_have;
        n_min        = r_min;
        n_nz_mask    = r_nz_mask;
        n_z_mask     = r_z_mask;
        n_emit_mask  = r_emit_mask;
        n_emit_vld   = w_emit_issue;
        n_emit_last  = w_mask_rest == '0;
        n_msg_vld    = w_accept && (w_bad || !w_any_open);
        n_msg_status = w_bad ? STATUS_ERROR : STATUS_ENDED;

        // a new round clears the scan results
        if (w_round) begin
            n_ptr     = '0;
            n_have    = 1'b0;
            n_nz_mask = '0;
            n_z_mask  = '0;
        end

        // step the scan address
        if (w_scan_issue) begin
            n_ptr = r_ptr + XW'(1);
        end

        // fold one head into the running minimum
        if (r_rd_vld && w_rd_live) begin
            if (w_rd_time != '0) begin
                if (!r_have || w_rd_time < r_min) begin
                    n_have    = 1'b1;
                    n_min     = w_rd_time;
                    n_nz_mask = w_rd_bit;
                end else if (w_rd_time == r_min) begin
                    n_nz_mask = r_nz_mask | w_rd_bit;
                end
            end else begin
                n_z_mask = r_z_mask | w_rd_bit;
            end
        end

        // pick the tie set to emit
        if (w_scan_done) begin
            n_emit_mask = r_have ? r_nz_mask : r_z_mask;
        end

        // emit one record and free its head
        if (w_emit_issue) begin
            n_emit_mask = w_mask_rest;
            n_valid     = r_valid & ~(ONE << w_pick);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_open      <= '1;
            r_rd_vld    <= 1'b0;
            r_emit_vld  <= 1'b0;
            r_msg_vld   <= 1'b0;
            r_emit_mask <= '0;
            r_count     <= COUNT_RST;
            r_add_src   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_open      <= n_open;
            r_rd_vld    <= n_rd_vld;
            r_emit_vld  <= n_emit_vld;
            r_msg_vld   <= n_msg_vld;
            r_emit_mask <= n_emit_mask;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SOURCE_COUNT: begin
                        if (i_cfg_data == '0) begin
                            r_count <= 4'd1;
                        end else if (XW'(i_cfg_data) > XW'(NUM_SOURCES)) begin
                            r_count <= 4'(NUM_SOURCES);
                        end else begin
                            r_count <= i_cfg_data;
                        end
                    end
                    CFG_ADD_SOURCE: begin
                        r_add_src <= i_cfg_data[0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // scan and result payload registers
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_rd_idx     <= n_rd_idx;
        r_have       <= n_have;
        r_min        <= n_min;
        r_nz_mask    <= n_nz_mask;
        r_z_mask     <= n_z_mask;
        r_emit_last  <= n_emit_last;
        r_msg_status <= n_msg_status;
    end

    assign o_cfg_ready = 1'b1;

    // result word
    always_comb begin
        o_strobe = r_emit_vld || r_msg_vld;
        if (r_emit_vld) begin
            o_out.status     = STATUS_RECORD;
            o_out.source_out = r_add_src ? 3'(r_rd_idx) : 3'd0;
            o_out.time_out   = 32'(w_rd_time);
            o_out.tag_out    = 32'(w_rd_tag);
            o_out.last       = r_emit_last;
        end else begin
            o_out.status     = r_msg_status;
            o_out.source_out = 3'd0;
            o_out.time_out   = 32'd0;
            o_out.tag_out    = 32'd0;
            o_out.last       = 1'b1;
        end
    end
endmodule

[tb/testbench.sv]
// self-checking testbench for the k-way timestamp merge unit
`timescale 1ns / 100ps

module testbench;
    import kwm_pkg::*;

    localparam int N_SRC        = NUM_SOURCES_DEF;
    localparam int SETTLE_CYCLES = 2 * N_SRC + 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 8;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_in_word               i_in;
    logic                   o_strobe;
    t_out_word              o_out;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    kway_timestamp_merge_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow of the merge state and registers
    bit          head_full [N_SRC];
    bit          src_open  [N_SRC];
    logic [31:0] head_ts   [N_SRC];
    logic [31:0] head_tag  [N_SRC];
    int unsigned use_count;
    bit          tag_source;

    // result words still to come, oldest first
    t_out_word merged_words[$];

    int  fail_count;
    int  cycle_count;
    bit  quiet;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // compare each strobed result word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (merged_words.size() == 0) begin
                $error("result word with nothing pending: %h", o_out);
                fail_count++;
            end else begin
                want = merged_words.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    fail_count++;
                end
                if (o_out.source_out !== want.source_out) begin
                    $error("source_out: expected %0d, got %0d",
                           want.source_out, o_out.source_out);
                    fail_count++;
                end
                if (o_out.time_out !== want.time_out) begin
                    $error("time_out: expected %h, got %h", want.time_out, o_out.time_out);
                    fail_count++;
                end
                if (o_out.tag_out !== want.tag_out) begin
                    $error("tag_out: expected %h, got %h", want.tag_out, o_out.tag_out);
                    fail_count++;
                end
                if (o_out.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out.last);
                    fail_count++;
                end
            end
        end
    end

    // shadow state after reset
    task automatic merge_reset();
        for (int i = 0; i < N_SRC; i++) begin
            head_full[i] = 1'b0;
            src_open[i]  = 1'b1;
            head_ts[i]   = '0;
            head_tag[i]  = '0;
        end
        use_count  = 8;
        tag_source = 1'b0;
    endtask

    // register write as seen by the shadow
    task automatic merge_config(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_SOURCE_COUNT) begin
            if (data == 0)
                use_count = 1;
            else if (data > N_SRC)
                use_count = N_SRC;
            else
                use_count = data;
        end else if (idx == CFG_ADD_SOURCE) begin
            tag_source = data[0];
        end
    endtask

    function automatic bit rejects(input t_in_word w);
        int unsigned s;
        s = w.source_index;
        return (s >= use_count) || !src_open[s] || head_full[s];
    endfunction

    // apply one accepted word and queue the results it causes
    task automatic merge_heads(input t_in_word w);
        int unsigned s;
        bit          any_open;
        bit          all_full;
        bit          have_min;
        logic [31:0] min_ts;
        t_out_word   r;
        t_out_word   round[$];
        s = w.source_index;
        r = '0;
        r.last = 1'b1;
        if (rejects(w)) begin
            r.status = STATUS_ERROR;
            merged_words.push_back(r);
            return;
        end
        if (w.opcode == OP_HEAD) begin
            head_ts[s]   = w.timestamp;
            head_tag[s]  = w.record_tag;
            head_full[s] = 1'b1;
        end else begin
            src_open[s] = 1'b0;
        end
        any_open = 1'b0;
        all_full = 1'b1;
        have_min = 1'b0;
        min_ts   = '0;
        for (int i = 0; i < use_count; i++) begin
            if (src_open[i]) begin
                any_open = 1'b1;
                if (!head_full[i])
                    all_full = 1'b0;
                else if (head_ts[i] != 0 && (!have_min || head_ts[i] < min_ts)) begin
                    min_ts   = head_ts[i];
                    have_min = 1'b1;
                end
            end
        end
        if (!any_open) begin
            r.status = STATUS_ENDED;
            merged_words.push_back(r);
            return;
        end
        if (!all_full)
            return;
        // with no nonzero head min_ts is zero and the held heads drain
        for (int i = 0; i < use_count; i++) begin
            if (src_open[i] && head_full[i] && head_ts[i] == min_ts) begin
                r            = '0;
                r.status     = STATUS_RECORD;
                r.source_out = tag_source ? 3'(i) : 3'd0;
                r.time_out   = head_ts[i];
                r.tag_out    = head_tag[i];
                round.push_back(r);
                head_full[i] = 1'b0;
            end
        end
        if (round.size() > 0)
            round[round.size() - 1].last = 1'b1;
        foreach (round[k])
            merged_words.push_back(round[k]);
    endtask

    function automatic t_in_word make_word(input logic op, input int unsigned idx,
                                           input logic [31:0] ts, input logic [31:0] tag);
        t_in_word w;
        w.opcode       = op;
        w.source_index = 3'(idx);
        w.timestamp    = ts;
        w.record_tag   = tag;
        return w;
    endfunction

    // timestamps biased toward ties, zeros and the top of the range
    function automatic logic [31:0] rand_stamp();
        case ($urandom_range(7))
            0:       return '0;
            1, 2, 3: return 32'($urandom_range(4, 1));
            4:       return 32'hFFFF_FFFF;
            5:       return 32'hFFFF_FFFF - 32'($urandom_range(3));
            default: return 32'($urandom);
        endcase
    endfunction

    // random open source in use with no head, or -1
    function automatic int pick_empty_source();
        int cand[$];
        for (int i = 0; i < use_count; i++)
            if (src_open[i] && !head_full[i])
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    function automatic bit any_in_use_open();
        for (int i = 0; i < use_count; i++)
            if (src_open[i])
                return 1'b1;
        return 1'b0;
    endfunction

    // send one input word; returns at the edge that accepted it, start left high
    task automatic issue_word(input t_in_word w);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= w;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        merge_heads(w);
    endtask

    // word that the block must turn down, with a fallback head
    task automatic issue_noise();
        t_in_word w;
        for (int k = 0; k < 6; k++) begin
            w = make_word(1'($urandom_range(1)), $urandom_range(7), $urandom, $urandom);
            if (rejects(w)) begin
                issue_word(w);
                return;
            end
        end
        issue_word(make_word(OP_HEAD, $urandom_range(7), rand_stamp(), $urandom));
    endtask

    // drop start, let every pending result arrive, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (merged_words.size() != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register write over the config channel, block idle
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        while (!quiet && $urandom_range(99) < IDLE_PCT)
            @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        merge_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ties, zero stamps held back, all-zero release, extremes, full-source errors
    task automatic test_directed_heads();
        logic [31:0] first_ts [N_SRC];
        first_ts = '{32'hFFFF_FFFF, 32'd0, 32'd5, 32'd5, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd7};
        issue_word(make_word(OP_HEAD, 0, first_ts[0], 32'd0));
        issue_word(make_word(OP_HEAD, 1, first_ts[1], 32'hFFFF_FFFF));
        for (int i = 2; i < N_SRC; i++)
            issue_word(make_word(OP_HEAD, i, first_ts[i], $urandom));
        // record for a full source, end of a source holding a head
        issue_word(make_word(OP_HEAD, 0, 32'd3, $urandom));
        issue_word(make_word(OP_END, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue_word(make_word(OP_HEAD, 2, 32'd7, $urandom));
        issue_word(make_word(OP_HEAD, 3, 32'd7, $urandom));
        issue_word(make_word(OP_HEAD, 4, 32'd6, $urandom));
        issue_word(make_word(OP_HEAD, 4, 32'hFFFF_FFFF, $urandom));
        foreach (first_ts[i])
            if (i == 2 || i == 3 || i == 7)
                issue_word(make_word(OP_HEAD, i, 32'hFFFF_FFFF, $urandom));
        // only zero stamps left once these go in
        foreach (first_ts[i])
            if (i != 1 && i != 6)
                issue_word(make_word(OP_HEAD, i, 32'd0, $urandom));
        wait_idle();
    endtask

    // count saturation both ways, source tagging, unknown register indexes
    task automatic test_config_extremes();
        cfg_write(CFG_ADD_SOURCE, 4'b1111);
        cfg_write(CFG_SOURCE_COUNT, 4'd0);
        issue_word(make_word(OP_HEAD, 0, 32'd9, $urandom));
        issue_word(make_word(OP_HEAD, 3, 32'd9, $urandom));
        cfg_write(CFG_SPARE_A, 4'hF);
        cfg_write(CFG_SPARE_B, 4'h5);
        issue_word(make_word(OP_HEAD, 1, 32'd1, $urandom));
        cfg_write(CFG_SOURCE_COUNT, 4'd15);
        cfg_write(CFG_ADD_SOURCE, 4'b1110);
        issue_word(make_word(OP_HEAD, 7, 32'd2, $urandom));
        wait_idle();
    endtask

    // mostly well-formed head traffic over several settings, some rejects
    task automatic test_random_merge();
        int s;
        logic [CFG_DATA_W-1:0] cnt;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0:       cnt = 4'd8;
                3:       cnt = 4'd1;
                6:       cnt = 4'd15;
                default: cnt = 4'($urandom_range(15));
            endcase
            quiet = (phase == 4);
            cfg_write(CFG_SOURCE_COUNT, cnt);
            cfg_write(CFG_ADD_SOURCE, 4'($urandom_range(15)));
            for (int n = 0; n < 17; n++) begin
                s = pick_empty_source();
                if (s < 0 || $urandom_range(99) < 20)
                    issue_noise();
                else
                    issue_word(make_word(OP_HEAD, s, rand_stamp(), $urandom));
            end
        end
        quiet = 1'b0;
        wait_idle();
    endtask

    // close sources with heads interleaved until none in use is open
    task automatic drain_sources(input int end_pct);
        int s;
        for (int n = 0; n < 400 && any_in_use_open(); n++) begin
            s = pick_empty_source();
            if (s < 0 || $urandom_range(99) < 10)
                issue_noise();
            else if ($urandom_range(99) < end_pct)
                issue_word(make_word(OP_END, s, $urandom, $urandom));
            else
                issue_word(make_word(OP_HEAD, s, rand_stamp(), $urandom));
        end
    endtask

    // ending sources, all-ended result, errors afterwards
    task automatic test_source_end();
        cfg_write(CFG_SOURCE_COUNT, 4'd3);
        cfg_write(CFG_ADD_SOURCE, 4'd1);
        drain_sources(30);
        // record for an ended source, end of an ended source
        issue_word(make_word(OP_HEAD, 1, 32'd4, $urandom));
        issue_word(make_word(OP_END, 2, 32'd0, 32'd0));
        cfg_write(CFG_SOURCE_COUNT, 4'd8);
        drain_sources(15);
        issue_word(make_word(OP_HEAD, 7, 32'hFFFF_FFFF, $urandom));
        issue_word(make_word(OP_END, 0, 32'd0, 32'd0));
        wait_idle();
    endtask

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        merge_reset();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_heads();
        test_config_extremes();
        test_random_merge();
        test_source_end();
        wait_idle();

        if (fail_count == 0 && merged_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/kwm_pkg.sv
sv/kwm_head_ram.sv
sv/kway_timestamp_merge_unit.sv
tb/testbench.sv
